[hdl/line_segment_strip_chainer_core_defines.svh]
// Assertion macros for the line segment strip chainer.
// No dependencies; included by the modules that carry assertions.
`ifndef LINE_SEGMENT_STRIP_CHAINER_CORE_DEFINES_SVH
`define LINE_SEGMENT_STRIP_CHAINER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lssc_pkg.sv]
// Shared constants, types and helper functions for the strip chainer.
// No dependencies.
package lssc_pkg;

	localparam int unsigned LSSC_MAX_SEGMENTS_DEF = 32;
	localparam int unsigned LSSC_MAX_WORDS_DEF    = 4;
	localparam int unsigned WORD_W                = 16;
	localparam int unsigned PORT_WORDS            = 4;
	localparam int unsigned CFG_W                 = 3;
	localparam int unsigned TOTAL_W               = 6;

	typedef logic [PORT_WORDS-1:0][WORD_W-1:0] vertex_t;

	typedef struct packed {
		logic                 push;
		logic                 first;
		vertex_t              vtx;
		logic                 close;
		logic                 finish;
		logic [TOTAL_W-1:0]   total;
	} emit_cmd_t;

	function automatic logic [CFG_W-1:0] word_total(input logic [CFG_W-1:0] oc,
		input int unsigned maxw);
		logic [CFG_W-1:0] k;
		k = oc;
		if (oc == '0)
			k = CFG_W'(1);
		else if (oc > CFG_W'(maxw))
			k = CFG_W'(maxw);
		return k;
	endfunction

	function automatic vertex_t mask_words(input vertex_t v, input logic [CFG_W-1:0] k);
		vertex_t r;
		r = v;
		for (int w = 0; w < PORT_WORDS; w++) begin
			if (CFG_W'(w) >= k)
				r[w] = '0;
		end
		return r;
	endfunction

endpackage

[hdl/lssc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lssc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[hdl/lssc_emit.sv]
// Result stage: holds one pending vertex until its strip and set marks are known.
// Depends on lssc_pkg.
module lssc_emit
	import lssc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  emit_cmd_t           cmd,
	output logic                result_strobe,
	output logic [WORD_W-1:0]   out_idx0,
	output logic [WORD_W-1:0]   out_idx1,
	output logic [WORD_W-1:0]   out_idx2,
	output logic [WORD_W-1:0]   out_idx3,
	output logic                strip_first,
	output logic                strip_last,
	output logic                all_done,
	output logic [TOTAL_W-1:0]  strip_total
);

	logic               pend_v_q;
	logic               pend_first_q;
	logic               pend_last_q;
	vertex_t            pend_vtx_q;
	logic               strobe_q;
	vertex_t            vtx_q;
	logic               first_q;
	logic               last_q;
	logic               done_q;
	logic [TOTAL_W-1:0] total_q;
	logic               fire;

	assign fire = pend_v_q && (cmd.push || cmd.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			pend_last_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= fire;
			if (cmd.push) begin
				pend_v_q    <= 1'b1;
				pend_last_q <= 1'b0;
			end else if (cmd.finish) begin
				pend_v_q    <= 1'b0;
				pend_last_q <= 1'b0;
			end else if (cmd.close) begin
				pend_last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_vtx_q   <= cmd.vtx;
			pend_first_q <= cmd.first;
		end
		if (fire) begin
			vtx_q   <= pend_vtx_q;
			first_q <= pend_first_q;
			last_q  <= pend_last_q || cmd.finish;
			done_q  <= cmd.finish;
			total_q <= cmd.finish ? cmd.total : '0;
		end
	end

	assign result_strobe = strobe_q;
	assign out_idx0      = vtx_q[0];
	assign out_idx1      = vtx_q[1];
	assign out_idx2      = vtx_q[2];
	assign out_idx3      = vtx_q[3];
	assign strip_first   = first_q;
	assign strip_last    = last_q;
	assign all_done      = done_q;
	assign strip_total   = total_q;

endmodule

[hdl/line_segment_strip_chainer_core.sv]
// Segments are stored one per cycle while busy is low; after the last segment the chaining
// pass opens each strip through ST_OPEN, ST_OPEN_RD and ST_OPEN_END and scans the segment
// RAMs one entry a cycle, restarting at entry 0 after a hit. Busy stays high through the
// whole pass, so no new segment is taken meanwhile; results trail their search by a vertex.
// Reset: arst_n clears control, counts and used flags; RAM contents need no clearing.
`include "line_segment_strip_chainer_core_defines.svh"
module line_segment_strip_chainer_core
	import lssc_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = LSSC_MAX_SEGMENTS_DEF,
	parameter int unsigned MAX_WORDS    = LSSC_MAX_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [WORD_W-1:0]   start_idx0,
	input  logic [WORD_W-1:0]   start_idx1,
	input  logic [WORD_W-1:0]   start_idx2,
	input  logic [WORD_W-1:0]   start_idx3,
	input  logic [WORD_W-1:0]   end_idx0,
	input  logic [WORD_W-1:0]   end_idx1,
	input  logic [WORD_W-1:0]   end_idx2,
	input  logic [WORD_W-1:0]   end_idx3,
	input  logic                last_segment,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	output logic                result_strobe,
	output logic [WORD_W-1:0]   out_idx0,
	output logic [WORD_W-1:0]   out_idx1,
	output logic [WORD_W-1:0]   out_idx2,
	output logic [WORD_W-1:0]   out_idx3,
	output logic                strip_first,
	output logic                strip_last,
	output logic                all_done,
	output logic [TOTAL_W-1:0]  strip_total
);

	localparam int unsigned TUP_W = WORD_W * MAX_WORDS;
	localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_OPEN     = 3'd1;
	localparam logic [2:0] ST_OPEN_RD  = 3'd2;
	localparam logic [2:0] ST_OPEN_END = 3'd3;
	localparam logic [2:0] ST_SCAN     = 3'd4;

	logic [2:0]              state_q, state_d;
	logic [CNT_W-1:0]        seg_cnt_q;
	logic [MAX_SEGMENTS-1:0] used_q;
	logic [TOTAL_W-1:0]      strip_cnt_q;
	logic [CFG_W-1:0]        oc_q;
	logic [TUP_W-1:0]        cur_q;
	logic [CNT_W-1:0]        addr_q;
	logic                    rv_s1;
	logic [IDX_W-1:0]        idx_s1;

	logic [TUP_W-1:0]        st_tup, en_tup, st_rd, en_rd;
	vertex_t                 st_in, en_in;
	vertex_t                 st_rd_v, en_rd_v, cur_v;
	logic [CFG_W-1:0]        k;
	logic                    ram_we;
	logic [IDX_W-1:0]        raddr;
	logic [IDX_W-1:0]        first_idx;
	logic                    first_found;
	logic                    issuing;
	logic                    hit;
	emit_cmd_t               cmd;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign k         = word_total(oc_q, MAX_WORDS);
	assign issuing   = (addr_q < seg_cnt_q);
	assign ram_we    = start && !busy && (seg_cnt_q < CNT_W'(MAX_SEGMENTS));

	assign st_in = {start_idx3, start_idx2, start_idx1, start_idx0};
	assign en_in = {end_idx3, end_idx2, end_idx1, end_idx0};

	always_comb begin
		st_tup = '0;
		en_tup = '0;
		for (int w = 0; w < MAX_WORDS; w++) begin
			st_tup[w*WORD_W +: WORD_W] = st_in[w];
			en_tup[w*WORD_W +: WORD_W] = en_in[w];
		end
	end

	assign st_rd_v = vertex_t'((PORT_WORDS*WORD_W)'(st_rd));
	assign en_rd_v = vertex_t'((PORT_WORDS*WORD_W)'(en_rd));
	assign cur_v   = vertex_t'((PORT_WORDS*WORD_W)'(cur_q));

	always_comb begin
		first_idx   = '0;
		first_found = 1'b0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!used_q[i] && (CNT_W'(i) < seg_cnt_q)) begin
				first_idx   = IDX_W'(i);
				first_found = 1'b1;
			end
		end
	end

	assign hit = (state_q == ST_SCAN) && rv_s1 && !used_q[idx_s1] &&
		(mask_words(st_rd_v, k) == mask_words(cur_v, k));

	always_comb begin
		state_d   = state_q;
		raddr     = addr_q[IDX_W-1:0];
		cmd       = '0;
		cmd.total = strip_cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (start && last_segment)
					state_d = ST_OPEN;
			end
			ST_OPEN: begin
				raddr = first_idx;
				if (first_found) begin
					state_d = ST_OPEN_RD;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_OPEN_RD: begin
				cmd.push  = 1'b1;
				cmd.first = 1'b1;
				cmd.vtx   = mask_words(st_rd_v, k);
				state_d   = ST_OPEN_END;
			end
			ST_OPEN_END: begin
				cmd.push = 1'b1;
				cmd.vtx  = mask_words(cur_v, k);
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit) begin
					cmd.push = 1'b1;
					cmd.vtx  = mask_words(en_rd_v, k);
				end else if (!issuing && !rv_s1) begin
					cmd.close = 1'b1;
					state_d   = ST_OPEN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_cnt_q   <= '0;
			used_q      <= '0;
			strip_cnt_q <= '0;
			oc_q        <= CFG_W'(1);
			addr_q      <= '0;
			rv_s1       <= 1'b0;
			idx_s1      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				oc_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (ram_we)
						seg_cnt_q <= seg_cnt_q + CNT_W'(1);
				end
				ST_OPEN: begin
					if (first_found) begin
						used_q[first_idx] <= 1'b1;
					end else begin
						seg_cnt_q   <= '0;
						used_q      <= '0;
						strip_cnt_q <= '0;
					end
				end
				ST_OPEN_END: begin
					addr_q <= '0;
					rv_s1  <= 1'b0;
				end
				ST_SCAN: begin
					if (hit) begin
						used_q[idx_s1] <= 1'b1;
						addr_q         <= '0;
						rv_s1          <= 1'b0;
					end else begin
						rv_s1  <= issuing;
						idx_s1 <= addr_q[IDX_W-1:0];
						if (issuing)
							addr_q <= addr_q + CNT_W'(1);
						if (cmd.close)
							strip_cnt_q <= strip_cnt_q + TOTAL_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OPEN_RD) || hit)
			cur_q <= en_rd;
	end

	lssc_ram #(
		.WIDTH(TUP_W),
		.DEPTH(MAX_SEGMENTS)
	) u_start_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(seg_cnt_q[IDX_W-1:0]),
		.wdata(st_tup),
		.raddr(raddr),
		.rdata(st_rd)
	);

	lssc_ram #(
		.WIDTH(TUP_W),
		.DEPTH(MAX_SEGMENTS)
	) u_end_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(seg_cnt_q[IDX_W-1:0]),
		.wdata(en_tup),
		.raddr(raddr),
		.rdata(en_rd)
	);

	lssc_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.result_strobe(result_strobe),
		.out_idx0     (out_idx0),
		.out_idx1     (out_idx1),
		.out_idx2     (out_idx2),
		.out_idx3     (out_idx3),
		.strip_first  (strip_first),
		.strip_last   (strip_last),
		.all_done     (all_done),
		.strip_total  (strip_total)
	);

	`LSSC_ASSERT_NXT(a_last_busy, clk, arst_n, start && !busy && last_segment, busy, "last segment did not start chaining")
	`LSSC_ASSERT_IMP(a_done_last, clk, arst_n, result_strobe && all_done, strip_last, "final vertex not marked strip end")
	`LSSC_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, seg_cnt_q <= CNT_W'(MAX_SEGMENTS), "segment count overflow")
	`LSSC_ASSERT_NXT(a_finish_out, clk, arst_n, (state_q == ST_OPEN) && !first_found, result_strobe && all_done, "set finished without final transaction")

endmodule

[tb/tb_line_segment_strip_chainer_core.sv]
// Self-checking testbench for line_segment_strip_chainer_core: a directed table, then random
// segment sets, checked per vertex against an in-bench chaining predictor.
// Depends on lssc_pkg and the core RTL only.
module tb_line_segment_strip_chainer_core;
	import lssc_pkg::*;

	localparam int SEG_DEPTH = LSSC_MAX_SEGMENTS_DEF;
	localparam int SETTLE    = 2 * SEG_DEPTH + 16;
	localparam int PHASE_ITEMS = 25;

	typedef struct {
		vertex_t            vtx;
		logic               opens;
		logic               closes;
		logic               done;
		logic [TOTAL_W-1:0] total;
	} strip_vertex_t;

	typedef struct packed {
		bit               cfg_en;
		logic [CFG_W-1:0] cfg_val;
		vertex_t          s;
		vertex_t          e;
		bit               ends_set;
		bit               typed;
		vertex_t          ts;
		vertex_t          te;
	} dir_row_t;

	localparam int DIR_ROWS = 17;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{1'b0, 3'd0, 64'h5A5A_A5A5_1234_FFFF, 64'hFFFF_FFFF_FFFF_0000, 1'b1, 1'b1,
			64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0000},
		'{1'b1, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000},
		'{1'b1, 3'd0, 64'hFFFF_FFFF_FFFF_0001, 64'h0001_5555_AAAA_8000, 1'b1, 1'b1,
			64'h0000_0000_0000_0001, 64'h0000_0000_0000_8000},
		'{1'b1, 3'd7, 64'h0004_0003_0002_0001, 64'h0008_0007_0006_0005, 1'b1, 1'b1,
			64'h0004_0003_0002_0001, 64'h0008_0007_0006_0005},
		'{1'b1, 3'd2, 64'hAAAA_BBBB_0000_0001, 64'h1111_2222_0000_0002, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h9999_7777_0000_0002, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h5555_3333_FFFF_FFFF, 64'hFFFF_FFFF_0000_0001, 1'b1, 1'b0, '0, '0},
		'{1'b1, 3'd3, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h0000_0000_0000_0004, 64'h0000_0000_0000_0002, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h0000_0000_0000_0002, 64'h0000_0000_0000_0003, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h0000_0000_0000_0002, 64'h0000_0000_0000_0005, 1'b1, 1'b0, '0, '0},
		'{1'b1, 3'd1, 64'hFFFF_0000_8000_0007, 64'h0000_FFFF_0000_0007, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h1234_5678_9ABC_0007, 64'h8000_0001_7FFF_0007, 1'b1, 1'b0, '0, '0},
		'{1'b1, 3'd5, 64'h0000_0000_0000_0000, 64'h0001_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_0000_0000_0000, 1'b0, 1'b0, '0, '0},
		'{1'b0, 3'd0, 64'h0001_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1, 1'b0, '0, '0},
		'{1'b1, 3'd6, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
			64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [WORD_W-1:0]  start_idx0, start_idx1, start_idx2, start_idx3;
	logic [WORD_W-1:0]  end_idx0, end_idx1, end_idx2, end_idx3;
	logic               last_segment;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data;
	logic               result_strobe;
	logic [WORD_W-1:0]  out_idx0, out_idx1, out_idx2, out_idx3;
	logic               strip_first;
	logic               strip_last;
	logic               all_done;
	logic [TOTAL_W-1:0] strip_total;

	vertex_t          seg_start [SEG_DEPTH];
	vertex_t          seg_end [SEG_DEPTH];
	int               seg_fill;
	logic [CFG_W-1:0] offset_cfg;
	strip_vertex_t    set_out [2*SEG_DEPTH];
	int               set_n;
	strip_vertex_t    pending_vertices [$];

	int err_count;
	int segments_sent;
	int sets_sent;
	int random_segments;
	int vertices_checked;
	int totals_checked;
	int offset_writes;

	line_segment_strip_chainer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.start_idx0    (start_idx0),
		.start_idx1    (start_idx1),
		.start_idx2    (start_idx2),
		.start_idx3    (start_idx3),
		.end_idx0      (end_idx0),
		.end_idx1      (end_idx1),
		.end_idx2      (end_idx2),
		.end_idx3      (end_idx3),
		.last_segment  (last_segment),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.out_idx0      (out_idx0),
		.out_idx1      (out_idx1),
		.out_idx2      (out_idx2),
		.out_idx3      (out_idx3),
		.strip_first   (strip_first),
		.strip_last    (strip_last),
		.all_done      (all_done),
		.strip_total   (strip_total)
	);

	always #5 clk = ~clk;

	function automatic int active_words(input logic [CFG_W-1:0] oc);
		if (oc == 3'd0)
			return 1;
		if (oc > 3'd4)
			return 4;
		return int'(oc);
	endfunction

	function automatic vertex_t keep_words(input vertex_t v, input int k);
		vertex_t r;
		r = v;
		for (int w = k; w < PORT_WORDS; w++)
			r[w] = '0;
		return r;
	endfunction

	// Append one expected vertex at the tail.
	task automatic queue_vertex(input strip_vertex_t r);
		pending_vertices = {pending_vertices, r};
	endtask

	// Store the segment; on the set's last segment, chain greedily into set_out.
	task automatic chain_segment(input vertex_t s, input vertex_t e, input bit ends_set);
		int k;
		int head;
		int nxt;
		int strips;
		bit [SEG_DEPTH-1:0] used;
		vertex_t cur;
		set_n = 0;
		if (seg_fill < SEG_DEPTH) begin
			seg_start[seg_fill] = s;
			seg_end[seg_fill] = e;
			seg_fill++;
		end
		if (!ends_set)
			return;
		k = active_words(offset_cfg);
		used = '0;
		strips = 0;
		forever begin
			head = -1;
			for (int i = 0; i < seg_fill; i++) begin
				if (!used[i]) begin
					head = i;
					break;
				end
			end
			if (head < 0)
				break;
			used[head] = 1'b1;
			set_out[set_n] = '{keep_words(seg_start[head], k), 1'b1, 1'b0, 1'b0, '0};
			set_n++;
			cur = seg_end[head];
			set_out[set_n] = '{keep_words(cur, k), 1'b0, 1'b0, 1'b0, '0};
			set_n++;
			forever begin
				nxt = -1;
				for (int i = 0; i < seg_fill; i++) begin
					if (!used[i] && keep_words(seg_start[i], k) == keep_words(cur, k)) begin
						nxt = i;
						break;
					end
				end
				if (nxt < 0)
					break;
				used[nxt] = 1'b1;
				cur = seg_end[nxt];
				set_out[set_n] = '{keep_words(cur, k), 1'b0, 1'b0, 1'b0, '0};
				set_n++;
			end
			set_out[set_n-1].closes = 1'b1;
			strips++;
		end
		set_out[set_n-1].done = 1'b1;
		set_out[set_n-1].total = TOTAL_W'(strips);
		seg_fill = 0;
	endtask

	// Entered and left at a falling edge.
	task automatic send_segment(input vertex_t s, input vertex_t e, input bit ends_set,
		input int idle_pct, input bit typed, input vertex_t ts, input vertex_t te);
		strip_vertex_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		start_idx0   <= s[0];
		start_idx1   <= s[1];
		start_idx2   <= s[2];
		start_idx3   <= s[3];
		end_idx0     <= e[0];
		end_idx1     <= e[1];
		end_idx2     <= e[2];
		end_idx3     <= e[3];
		last_segment <= ends_set;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		segments_sent++;
		if (ends_set)
			sets_sent++;
		chain_segment(s, e, ends_set);
		if (typed) begin
			r = '{ts, 1'b1, 1'b0, 1'b0, '0};
			queue_vertex(r);
			r = '{te, 1'b0, 1'b1, 1'b1, TOTAL_W'(1)};
			queue_vertex(r);
		end else begin
			for (int i = 0; i < set_n; i++)
				queue_vertex(set_out[i]);
		end
		@(negedge clk);
	endtask

	task automatic hold_until_drained(input int extra);
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_vertices.size() != 0);
		repeat (extra)
			@(negedge clk);
	endtask

	task automatic write_offset(input logic [CFG_W-1:0] v);
		hold_until_drained(SETTLE);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		offset_cfg = v;
		offset_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly chains over a small vertex pool, with junk in the ignored words and some noise.
	task automatic run_random_set(input int n, input int idle_pct);
		vertex_t pool [6];
		vertex_t s;
		vertex_t e;
		vertex_t cur;
		int np;
		int k;
		int roll;
		np = $urandom_range(2, 6);
		for (int i = 0; i < np; i++)
			pool[i] = {$urandom, $urandom};
		k = active_words(offset_cfg);
		cur = pool[0];
		for (int j = 0; j < n; j++) begin
			roll = $urandom_range(99);
			if (roll < 20) begin
				s = {$urandom, $urandom};
				e = {$urandom, $urandom};
			end else begin
				s = (roll < 70) ? cur : pool[$urandom_range(np - 1)];
				e = pool[$urandom_range(np - 1)];
				cur = e;
				if ($urandom_range(3) == 0) begin
					for (int w = k; w < PORT_WORDS; w++) begin
						s[w] = WORD_W'($urandom);
						e[w] = WORD_W'($urandom);
					end
				end
			end
			send_segment(s, e, j == n - 1, idle_pct, 1'b0, '0, '0);
			random_segments++;
		end
	endtask

	always @(posedge clk) begin
		strip_vertex_t want;
		if (arst_n && result_strobe) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected vertex idx=%h_%h_%h_%h first=%b last=%b done=%b total=%0d",
					$time, out_idx3, out_idx2, out_idx1, out_idx0, strip_first, strip_last,
					all_done, strip_total);
				err_count++;
			end else begin
				want = pending_vertices.pop_front();
				vertices_checked++;
				if (want.done)
					totals_checked++;
				if (out_idx0 !== want.vtx[0] || out_idx1 !== want.vtx[1] ||
					out_idx2 !== want.vtx[2] || out_idx3 !== want.vtx[3] ||
					strip_first !== want.opens || strip_last !== want.closes ||
					all_done !== want.done || strip_total !== want.total) begin
					$display("%0t: mismatch expected idx=%h_%h_%h_%h first=%b last=%b done=%b total=%0d",
						$time, want.vtx[3], want.vtx[2], want.vtx[1], want.vtx[0], want.opens,
						want.closes, want.done, want.total);
					$display("%0t:          actual idx=%h_%h_%h_%h first=%b last=%b done=%b total=%0d",
						$time, out_idx3, out_idx2, out_idx1, out_idx0, strip_first, strip_last,
						all_done, strip_total);
					err_count++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("line_segment_strip_chainer_core test failed");
		$finish;
	end

	initial begin
		int idle_pct [4];
		logic [CFG_W-1:0] phase_cfg [4];
		int phase_start;
		int n;
		idle_pct  = '{0, 81, 0, 36};
		phase_cfg = '{3'd3, 3'd5, 3'd4, 3'd1};
		arst_n       = 1'b0;
		start        = 1'b0;
		start_idx0   = '0;
		start_idx1   = '0;
		start_idx2   = '0;
		start_idx3   = '0;
		end_idx0     = '0;
		end_idx1     = '0;
		end_idx2     = '0;
		end_idx3     = '0;
		last_segment = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		seg_fill     = 0;
		offset_cfg   = 3'd1;
		err_count = 0;
		segments_sent = 0;
		sets_sent = 0;
		random_segments = 0;
		vertices_checked = 0;
		totals_checked = 0;
		offset_writes = 0;
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].cfg_en)
				write_offset(DIR_TAB[i].cfg_val);
			send_segment(DIR_TAB[i].s, DIR_TAB[i].e, DIR_TAB[i].ends_set, 0,
				DIR_TAB[i].typed, DIR_TAB[i].ts, DIR_TAB[i].te);
		end

		for (int p = 0; p < 4; p++) begin
			write_offset(phase_cfg[p]);
			phase_start = random_segments;
			// overflow the segment store once
			if (p == 2)
				run_random_set(SEG_DEPTH + 2, idle_pct[p]);
			while (random_segments - phase_start < PHASE_ITEMS) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
				run_random_set(n, idle_pct[p]);
				if ($urandom_range(4) == 0)
					hold_until_drained(0);
			end
		end

		hold_until_drained(SETTLE);
		$display("covered %0d segments (%0d random) in %0d sets over %0d offset settings;",
			segments_sent, random_segments, sets_sent, offset_writes + 1);
		$display("checked %0d strip vertices and %0d strip totals", vertices_checked,
			totals_checked);
		if (err_count == 0) begin
			$display("line_segment_strip_chainer_core test passed");
		end else begin
			$display("line_segment_strip_chainer_core test failed");
		end
		$finish;
	end

endmodule
